// File: design/lzsd_pkg.sv
package lzsd_pkg;

    // History storage; the depth is a power of two so addresses wrap naturally.
    localparam int HIST_DEPTH   = 256;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int FILL_W       = HIST_AW + 1;
    localparam int MAX_LEN_BITS = 4;
    localparam int MAX_RESULTS  = 46;
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

    // Longest token: flag, index and count.
    localparam int ACC_W        = 1 + HIST_AW + MAX_LEN_BITS;
    localparam int HELD_W       = $clog2(ACC_W + 1);
    localparam int NEED_W       = HELD_W + 1;
    localparam int LIT_TOKEN    = 9;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    // Configuration register file.
    localparam int HB_W         = 4;
    localparam int LB_W         = 3;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_BITS  = 1'b1;
    localparam logic [HB_W-1:0] HB_RESET = 4'd8;
    localparam logic [LB_W-1:0] LB_RESET = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_LITERAL = 2'd0;
    localparam logic [1:0] ST_COPY    = 2'd1;
    localparam logic [1:0] ST_BEYOND  = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_MATCH,
        CMD_TRUNC,
        CMD_FLUSH
    } cmd_kind_t;

    // One decoded token handed from the parser to the executor.
    typedef struct packed {
        cmd_kind_t                kind;
        logic [HIST_AW-1:0]       val;       // literal byte or match index
        logic [MAX_LEN_BITS-1:0]  cnt;
        logic                     item_last; // final command of its input byte
        logic                     eos;       // input byte closed the stream
    } cmd_t;

    typedef struct packed {
        logic [HB_W-1:0] hist_bits;
        logic [LB_W-1:0] len_bits;
    } cfg_t;

    function automatic logic [HB_W-1:0] clamp_hist_bits(input logic [HB_W-1:0] v);
        logic [HB_W-1:0] r;
        r = v;
        if (v == '0)
            r = HB_W'(1);
        else if (v > HB_W'(HIST_AW))
            r = HB_W'(HIST_AW);
        return r;
    endfunction

    function automatic logic [LB_W-1:0] clamp_len_bits(input logic [LB_W-1:0] v);
        logic [LB_W-1:0] r;
        r = v;
        if (v == '0)
            r = LB_W'(1);
        else if (v > LB_W'(MAX_LEN_BITS))
            r = LB_W'(MAX_LEN_BITS);
        return r;
    endfunction

endpackage

// File: design/lzss_literal_history_decoder.sv
// Parsing: an input byte passes through the bit parser states F_BITS, F_TRUNC and F_FIN,
// one bit a cycle while the command queue has room; no new byte is taken until F_IDLE.
// Execution: a literal passes through B_EMIT and each copied byte through B_RD (history
// read) and B_COPY (result), so long matches are paced by the registered history read.
// Reset (rst_n low, asynchronous) clears parser, queue, counters, output and history fill,
// sets the config registers to their defaults and leaves the history memory as it is.
module lzss_literal_history_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [7:0] in_byte, [11:8] valid_bits
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic [2:0]                    m_tuser,   // [1:0] status, [2] end_of_stream
    output logic                          m_tlast,   // last_of_item
    input  logic                          cfg_we,
    input  logic [lzsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lzsd_pkg::CFG_W-1:0]    cfg_wdata
);

    logic [lzsd_pkg::HB_W-1:0] history_bits_reg;
    logic [lzsd_pkg::LB_W-1:0] length_bits_reg;
    lzsd_pkg::cfg_t            cfg;

    logic           q_push;
    lzsd_pkg::cmd_t q_push_data;
    logic           q_full;
    logic           q_pop;
    lzsd_pkg::cmd_t q_pop_data;
    logic           q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_bits_reg <= lzsd_pkg::HB_RESET;
            length_bits_reg  <= lzsd_pkg::LB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lzsd_pkg::REG_HISTORY_BITS: history_bits_reg <= cfg_wdata[lzsd_pkg::HB_W-1:0];
                lzsd_pkg::REG_LENGTH_BITS:  length_bits_reg  <= cfg_wdata[lzsd_pkg::LB_W-1:0];
                default:                    history_bits_reg <= history_bits_reg;
            endcase
        end
    end

    assign cfg.hist_bits = lzsd_pkg::clamp_hist_bits(history_bits_reg);
    assign cfg.len_bits  = lzsd_pkg::clamp_len_bits(length_bits_reg);

    lzsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    lzsd_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    lzsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/lzsd_cmd_queue.sv
module lzsd_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lzsd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output lzsd_pkg::cmd_t pop_data,
    output logic          empty
);

    lzsd_pkg::cmd_t slot_reg [lzsd_pkg::QUEUE_DEPTH];
    logic [lzsd_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [lzsd_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [lzsd_pkg::QUEUE_AW:0]   count_reg;
    logic do_push;
    logic do_pop;

    assign full     = (count_reg == (lzsd_pkg::QUEUE_AW + 1)'(lzsd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: design/lzsd_front.sv
module lzsd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [15:0]    s_tdata,   // [7:0] in_byte, [11:8] valid_bits, [15:12] zero
    input  logic           s_tlast,
    input  lzsd_pkg::cfg_t cfg,
    input  logic           q_full,
    output logic           q_push,
    output lzsd_pkg::cmd_t q_data
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_BITS,
        F_TRUNC,
        F_FIN
    } fstate_t;

    fstate_t                          state_reg;
    logic [7:0]                       byte_reg;
    logic [3:0]                       nbits_reg;
    logic [3:0]                       bit_idx_reg;
    logic                             last_reg;
    logic [lzsd_pkg::ACC_W-1:0]       acc_reg;
    logic [lzsd_pkg::HELD_W-1:0]      held_reg;
    logic                             pend_valid_reg;
    lzsd_pkg::cmd_t                   pend_reg;

    logic [3:0]                        nbits_in;
    logic                              bit_in;
    logic [lzsd_pkg::ACC_W-1:0]        acc_n;
    logic [lzsd_pkg::HELD_W-1:0]       held_n;
    logic                              flag;
    logic [lzsd_pkg::NEED_W-1:0]       need;
    logic                              done;
    logic [lzsd_pkg::MAX_LEN_BITS:0]   cnt_mask;
    logic [lzsd_pkg::MAX_LEN_BITS-1:0] cnt;
    logic [lzsd_pkg::ACC_W-1:0]        idx_sh;
    logic [lzsd_pkg::HIST_AW:0]        idx_mask;
    logic [lzsd_pkg::HIST_AW-1:0]      idx;
    logic                              has_cmd;
    logic                              bits_done;
    logic                              trunc_needed;
    logic                              bits_adv;
    logic                              trunc_adv;
    logic                              fin_adv;
    lzsd_pkg::cmd_t                    new_cmd;
    lzsd_pkg::cmd_t                    trunc_cmd;
    lzsd_pkg::cmd_t                    flush_cmd;

    assign s_tready = (state_reg == F_IDLE);
    assign nbits_in = (s_tdata[11:8] > 4'd8) ? 4'd8 : s_tdata[11:8];

    // Next bit of the byte, appended at the bottom of the token accumulator.
    assign bit_in = byte_reg[bit_idx_reg[2:0]];
    assign acc_n  = {acc_reg[lzsd_pkg::ACC_W-2:0], bit_in};
    assign held_n = held_reg + 1'b1;
    assign flag   = acc_n[held_n - 1'b1];
    assign need   = flag ? (lzsd_pkg::NEED_W'(1) + lzsd_pkg::NEED_W'(cfg.hist_bits)
                            + lzsd_pkg::NEED_W'(cfg.len_bits))
                         : lzsd_pkg::NEED_W'(lzsd_pkg::LIT_TOKEN);
    assign done   = (lzsd_pkg::NEED_W'(held_n) >= need);

    assign cnt_mask = (lzsd_pkg::MAX_LEN_BITS + 1)'(((lzsd_pkg::MAX_LEN_BITS + 1)'(1)
                      << cfg.len_bits) - 1'b1);
    assign cnt      = acc_n[lzsd_pkg::MAX_LEN_BITS-1:0] & cnt_mask[lzsd_pkg::MAX_LEN_BITS-1:0];
    assign idx_sh   = acc_n >> cfg.len_bits;
    assign idx_mask = (lzsd_pkg::HIST_AW + 1)'(((lzsd_pkg::HIST_AW + 1)'(1)
                      << cfg.hist_bits) - 1'b1);
    assign idx      = idx_sh[lzsd_pkg::HIST_AW-1:0] & idx_mask[lzsd_pkg::HIST_AW-1:0];

    // A match with a zero count produces nothing and is not queued.
    assign has_cmd      = !flag || (cnt != '0);
    assign bits_done    = (bit_idx_reg == nbits_reg);
    assign trunc_needed = last_reg && (held_reg != '0);

    always_comb
    begin
        new_cmd.kind      = flag ? lzsd_pkg::CMD_MATCH : lzsd_pkg::CMD_LIT;
        new_cmd.val       = flag ? idx : acc_n[lzsd_pkg::HIST_AW-1:0];
        new_cmd.cnt       = flag ? cnt : '0;
        new_cmd.item_last = 1'b0;
        new_cmd.eos       = last_reg;

        trunc_cmd.kind      = lzsd_pkg::CMD_TRUNC;
        trunc_cmd.val       = '0;
        trunc_cmd.cnt       = '0;
        trunc_cmd.item_last = 1'b0;
        trunc_cmd.eos       = 1'b1;

        flush_cmd.kind      = lzsd_pkg::CMD_FLUSH;
        flush_cmd.val       = '0;
        flush_cmd.cnt       = '0;
        flush_cmd.item_last = 1'b1;
        flush_cmd.eos       = 1'b1;
    end

    assign bits_adv  = !(done && has_cmd && pend_valid_reg && q_full);
    assign trunc_adv = !(trunc_needed && pend_valid_reg && q_full);
    assign fin_adv   = !((pend_valid_reg || last_reg) && q_full);

    // The newest token is held back until the next one or the end of the byte
    // shows whether it is the final command of this byte.
    always_comb
    begin
        q_push = 1'b0;
        q_data = pend_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                q_push = 1'b0;
            end
            F_BITS:
            begin
                q_push = !bits_done && done && has_cmd && pend_valid_reg && !q_full;
            end
            F_TRUNC:
            begin
                q_push = trunc_needed && pend_valid_reg && !q_full;
            end
            F_FIN:
            begin
                if (pend_valid_reg)
                begin
                    q_push           = !q_full;
                    q_data.item_last = 1'b1;
                end
                else if (last_reg)
                begin
                    q_push = !q_full;
                    q_data = flush_cmd;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            byte_reg       <= '0;
            nbits_reg      <= '0;
            bit_idx_reg    <= '0;
            last_reg       <= 1'b0;
            acc_reg        <= '0;
            held_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        byte_reg    <= s_tdata[7:0];
                        nbits_reg   <= nbits_in;
                        last_reg    <= s_tlast;
                        bit_idx_reg <= '0;
                        state_reg   <= F_BITS;
                    end
                end
                F_BITS:
                begin
                    if (bits_done)
                        state_reg <= F_TRUNC;
                    else if (bits_adv)
                    begin
                        bit_idx_reg <= bit_idx_reg + 1'b1;
                        if (done)
                        begin
                            acc_reg  <= '0;
                            held_reg <= '0;
                            if (has_cmd)
                            begin
                                pend_reg       <= new_cmd;
                                pend_valid_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            acc_reg  <= acc_n;
                            held_reg <= held_n;
                        end
                    end
                end
                F_TRUNC:
                begin
                    if (trunc_adv)
                    begin
                        if (trunc_needed)
                        begin
                            pend_reg       <= trunc_cmd;
                            pend_valid_reg <= 1'b1;
                        end
                        if (last_reg)
                        begin
                            acc_reg  <= '0;
                            held_reg <= '0;
                        end
                        state_reg <= F_FIN;
                    end
                end
                F_FIN:
                begin
                    if (fin_adv)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/lzsd_back.sv
module lzsd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lzsd_pkg::cfg_t cfg,
    input  logic           q_empty,
    input  lzsd_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [7:0] out_byte
    output logic [2:0]     m_tuser,   // [1:0] status, [2] end_of_stream
    output logic           m_tlast
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_EMIT,
        B_RD,
        B_COPY
    } bstate_t;

    bstate_t                             state_reg;
    lzsd_pkg::cmd_t                      cmd_reg;
    logic [lzsd_pkg::MAX_LEN_BITS-1:0]   k_reg;
    logic [lzsd_pkg::RES_CNT_W-1:0]      count_reg;
    logic [lzsd_pkg::HIST_AW-1:0]        head_reg;
    logic [lzsd_pkg::FILL_W-1:0]         fill_reg;
    logic                                hit_reg;
    logic                                out_valid_reg;
    logic [7:0]                          out_byte_reg;
    logic [1:0]                          out_status_reg;
    logic                                out_last_reg;
    logic                                out_eos_reg;

    logic [7:0]                          hist_mem [lzsd_pkg::HIST_DEPTH];
    logic [7:0]                          rd_data_reg;

    logic [lzsd_pkg::FILL_W:0]           cap_wide;
    logic [lzsd_pkg::FILL_W:0]           cap;
    logic [lzsd_pkg::FILL_W:0]           fill_inc;
    logic                                lit_drop;
    logic [lzsd_pkg::FILL_W-1:0]         copy_pos;
    logic                                mem_we;
    logic [lzsd_pkg::HIST_AW-1:0]        mem_waddr;
    logic                                mem_re;
    logic [lzsd_pkg::HIST_AW-1:0]        mem_raddr;
    logic                                out_free;
    logic                                can_emit;
    logic                                final_res;
    logic                                emit;
    logic                                go;
    logic                                out_load;
    logic                                res_last;
    logic [7:0]                          res_byte;
    logic [1:0]                          res_status;

    assign cap_wide = (lzsd_pkg::FILL_W + 1)'(1) << cfg.hist_bits;
    assign cap      = (cap_wide > (lzsd_pkg::FILL_W + 1)'(lzsd_pkg::HIST_DEPTH))
                      ? (lzsd_pkg::FILL_W + 1)'(lzsd_pkg::HIST_DEPTH) : cap_wide;
    assign fill_inc = (lzsd_pkg::FILL_W + 1)'(fill_reg) + 1'b1;
    // Reaching capacity drops the oldest entry: the head moves, the fill stays.
    assign lit_drop = (fill_inc >= cap);

    assign copy_pos  = lzsd_pkg::FILL_W'(cmd_reg.val) + lzsd_pkg::FILL_W'(k_reg);
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign mem_we    = q_pop && (q_data.kind == lzsd_pkg::CMD_LIT);
    assign mem_waddr = head_reg + fill_reg[lzsd_pkg::HIST_AW-1:0];
    assign mem_re    = (state_reg == B_RD);
    assign mem_raddr = head_reg + copy_pos[lzsd_pkg::HIST_AW-1:0];

    assign out_free  = !out_valid_reg || m_tready;
    assign can_emit  = (count_reg < lzsd_pkg::RES_CNT_W'(lzsd_pkg::MAX_RESULTS));
    assign final_res = (state_reg == B_EMIT) || (k_reg == cmd_reg.cnt - 1'b1);
    assign emit      = can_emit && !((state_reg == B_EMIT)
                       && (cmd_reg.kind == lzsd_pkg::CMD_FLUSH));
    assign go        = !emit || out_free;
    assign out_load  = ((state_reg == B_EMIT) || (state_reg == B_COPY)) && go && emit;
    // Once the per-byte result budget is used up, its last result closes the byte.
    assign res_last  = (cmd_reg.item_last && final_res)
                       || (count_reg == lzsd_pkg::RES_CNT_W'(lzsd_pkg::MAX_RESULTS - 1));

    always_comb
    begin
        res_byte   = '0;
        res_status = lzsd_pkg::ST_TRUNC;
        if (state_reg == B_COPY)
        begin
            res_byte   = hit_reg ? rd_data_reg : 8'd0;
            res_status = hit_reg ? lzsd_pkg::ST_COPY : lzsd_pkg::ST_BEYOND;
        end
        else if (cmd_reg.kind == lzsd_pkg::CMD_LIT)
        begin
            res_byte   = cmd_reg.val;
            res_status = lzsd_pkg::ST_LITERAL;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_eos_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= q_data.val;
        if (mem_re)
            rd_data_reg <= hist_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            cmd_reg        <= '0;
            k_reg          <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_status_reg <= '0;
            out_last_reg   <= 1'b0;
            out_eos_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= res_byte;
                out_status_reg <= res_status;
                out_last_reg   <= res_last;
                out_eos_reg    <= res_last && cmd_reg.eos;
            end
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg <= q_data;
                        k_reg   <= '0;
                        if (q_data.kind == lzsd_pkg::CMD_LIT)
                        begin
                            if (lit_drop)
                                head_reg <= head_reg + 1'b1;
                            else
                                fill_reg <= fill_inc[lzsd_pkg::FILL_W-1:0];
                        end
                        state_reg <= (q_data.kind == lzsd_pkg::CMD_MATCH) ? B_RD : B_EMIT;
                    end
                end
                B_RD:
                begin
                    hit_reg   <= (copy_pos < fill_reg);
                    state_reg <= B_COPY;
                end
                B_EMIT, B_COPY:
                begin
                    if (go)
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (final_res && cmd_reg.item_last)
                            count_reg <= '0;
                        else if (emit)
                            count_reg <= count_reg + 1'b1;
                        if (final_res)
                        begin
                            if (cmd_reg.item_last && cmd_reg.eos)
                            begin
                                head_reg <= '0;
                                fill_reg <= '0;
                            end
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            state_reg <= B_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/lzsd_checker.sv
module lzsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("result changed while stalled");

    // Error results carry a zero byte.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == lzsd_pkg::ST_BEYOND || m_tuser[1:0] == lzsd_pkg::ST_TRUNC)
        |-> m_tdata == 8'd0)
        else $error("error result with nonzero byte");

    // End of stream only marks the final result of a byte.
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("end of stream without last of item");

    // A truncated token is always the closing result of the stream.
    a_trunc_eos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == lzsd_pkg::ST_TRUNC |-> m_tlast && m_tuser[2])
        else $error("truncation result not at end of stream");

    // The parser is not ready again in the cycle after it takes a byte.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind lzss_literal_history_decoder lzsd_checker u_lzsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
